FILE: rtl/core/spherical_frame_position_converter_core_defines.svh
// Assertion macros shared by the spherical frame position converter RTL.
`ifndef SPHERICAL_FRAME_POSITION_CONVERTER_CORE_DEFINES_SVH
`define SPHERICAL_FRAME_POSITION_CONVERTER_CORE_DEFINES_SVH
`ifndef SYNTH
// Same-cycle implication, disabled while reset is low.
`define SFPC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("sfpc: same-cycle check failed");
// Next-cycle implication, disabled while reset is low.
`define SFPC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("sfpc: next-cycle check failed");
`else
`define SFPC_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define SFPC_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

FILE: rtl/core/sfpc_pkg.sv
// Types, constants and helper functions of the spherical frame position converter.
package sfpc_pkg;

	localparam int CW = 40;
	localparam int MFB = 19;
	localparam int EB = 21;
	localparam int ROW_W = 3 * EB;
	localparam int RAD_W = 39;
	localparam int DW = 64;
	localparam int ZW = 35;
	localparam int ANG_W = 32;
	localparam int SU = 59 - CW;
	localparam int SW = 66;
	localparam int GAIN_W = 31;
	localparam int GAIN_FRAC = 31;
	localparam int CORDIC_STAGES_DEF = 24;
	localparam int CFG_IW = 3;

	localparam logic [GAIN_W-1:0] INV_GAIN = 31'd1304065748;

	localparam logic ACT_FWD = 1'b0;
	localparam logic ACT_INV = 1'b1;

	localparam logic [CFG_IW-1:0] REG_ROW_ZERO = 3'd0;
	localparam logic [CFG_IW-1:0] REG_ROW_ONE = 3'd1;
	localparam logic [CFG_IW-1:0] REG_ROW_TWO = 3'd2;
	localparam logic [CFG_IW-1:0] REG_RADIUS = 3'd3;

	localparam logic signed [ZW-1:0] HALF_TURN = {{(ZW-32){1'b0}}, 1'b1, 31'b0};
	localparam logic signed [ZW-1:0] QUARTER_TURN = {{(ZW-32){1'b0}}, 2'b01, 30'b0};

	typedef logic signed [CW-1:0] coord_t;
	typedef logic signed [EB-1:0] entry_t;

	localparam entry_t ENTRY_ONE = entry_t'(1 << MFB);

	typedef struct packed {
		logic action;
		logic signed [CW-1:0] coord_first;
		logic signed [CW-1:0] coord_second;
		logic signed [CW-1:0] coord_third;
	} req_t;

	typedef struct packed {
		logic signed [CW-1:0] result_first;
		logic signed [CW-1:0] result_second;
		logic signed [CW-1:0] result_third;
		logic saturated;
	} rsp_t;

	typedef struct packed {
		logic clip;
		logic signed [CW-1:0] val;
	} sat_t;

	// Clamp a wide signed value to the coordinate range and report clipping.
	function automatic sat_t sat_cw(input logic signed [SW-1:0] v);
		logic signed [SW-1:0] hi;
		logic signed [SW-1:0] lo;
		sat_t r;
		hi = {{(SW-CW+1){1'b0}}, {(CW-1){1'b1}}};
		lo = ~hi;
		r.clip = 1'b0;
		r.val = v[CW-1:0];
		if (v > hi) begin
			r.clip = 1'b1;
			r.val = hi[CW-1:0];
		end else if (v < lo) begin
			r.clip = 1'b1;
			r.val = lo[CW-1:0];
		end
		return r;
	endfunction

	// Arctangent of 2^-idx in binary-angle units, 2^32 per turn.
	function automatic logic [ANG_W-1:0] atan_step(input int unsigned idx);
		logic [ANG_W-1:0] t;
		case (idx)
			0: t = 32'h20000000;
			1: t = 32'h12E4051E;
			2: t = 32'h09FB385B;
			3: t = 32'h051111D4;
			4: t = 32'h028B0D43;
			5: t = 32'h0145D7E1;
			6: t = 32'h00A2F61E;
			7: t = 32'h00517C55;
			8: t = 32'h0028BE53;
			9: t = 32'h00145F2F;
			10: t = 32'h000A2F98;
			11: t = 32'h000517CC;
			12: t = 32'h00028BE6;
			13: t = 32'h000145F3;
			14: t = 32'h0000A2FA;
			15: t = 32'h0000517D;
			16: t = 32'h000028BE;
			17: t = 32'h0000145F;
			18: t = 32'h00000A30;
			19: t = 32'h00000518;
			20: t = 32'h0000028C;
			21: t = 32'h00000146;
			22: t = 32'h000000A3;
			23: t = 32'h00000051;
			24: t = 32'h00000029;
			25: t = 32'h00000014;
			26: t = 32'h0000000A;
			27: t = 32'h00000005;
			28: t = 32'h00000003;
			29: t = 32'h00000001;
			30: t = 32'h00000001;
			default: t = '0;
		endcase
		return t;
	endfunction

endpackage

FILE: rtl/core/sfpc_matrix.sv
// Three-stage 3x3 matrix times vector unit with half-up rounding and clipping.
module sfpc_matrix import sfpc_pkg::*; (
	input  logic   clk,
	input  logic   adv,
	input  coord_t v [3],
	input  entry_t e [3][3],
	output coord_t res [3],
	output logic   clip
);

	localparam int PW = CW + EB;
	localparam int AW = PW + 2;
	localparam logic signed [AW-1:0] HALF = AW'(1) <<< (MFB - 1);

	logic signed [PW-1:0] prod_s1 [3][3];
	logic signed [AW-1:0] acc_s2 [3];
	coord_t               res_s3 [3];
	logic                 clip_s3;

	logic signed [AW-1:0] rnd [3];
	sat_t                 sat_v [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			rnd[i] = (acc_s2[i] + HALF) >>> MFB;
			sat_v[i] = sat_cw(SW'(rnd[i]));
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					prod_s1[i][j] <= PW'(v[j] * e[i][j]);
				end
				acc_s2[i] <= AW'(prod_s1[i][0]) + AW'(prod_s1[i][1]) + AW'(prod_s1[i][2]);
				res_s3[i] <= sat_v[i].val;
			end
			clip_s3 <= sat_v[0].clip | sat_v[1].clip | sat_v[2].clip;
		end
	end

	assign res = res_s3;
	assign clip = clip_s3;

endmodule

FILE: rtl/core/sfpc_gain.sv
// Two-stage CORDIC gain compensation: multiply by the inverse gain and round, or pass through when disabled.
module sfpc_gain import sfpc_pkg::*; (
	input  logic                 clk,
	input  logic                 adv,
	input  logic                 en,
	input  logic signed [DW-1:0] v,
	output logic signed [DW-1:0] q
);

	localparam int HW = DW / 2;
	localparam int GW = DW + GAIN_FRAC;
	localparam logic signed [GW-1:0] HALF = GW'(1) <<< (GAIN_FRAC - 1);

	logic [HW+GAIN_W-1:0]  plo_s1;
	logic signed [DW-1:0]  phi_s1;
	logic signed [DW-1:0]  v_s1;
	logic                  en_s1;
	logic signed [DW-1:0]  q_s2;

	logic signed [GW-1:0] hi_t;
	logic signed [GW-1:0] lo_t;
	logic signed [GW-1:0] sum;

	// The operand is split in halves; the two partial products are recombined here with the rounding offset.
	always_comb begin
		hi_t = GW'(phi_s1) <<< HW;
		lo_t = GW'(plo_s1);
		sum = hi_t + lo_t + HALF;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			plo_s1 <= v[HW-1:0] * INV_GAIN;
			phi_s1 <= $signed(v[DW-1:HW]) * $signed({1'b0, INV_GAIN});
			v_s1 <= v;
			en_s1 <= en;
			q_s2 <= en_s1 ? sum[GW-1:GAIN_FRAC] : v_s1;
		end
	end

	assign q = q_s2;

endmodule

FILE: rtl/core/sfpc_cordic.sv
// Pipelined CORDIC: vectoring for the forward action, rotation for the inverse.
module sfpc_cordic import sfpc_pkg::*; #(
	parameter int STAGES = CORDIC_STAGES_DEF
) (
	input  logic                 clk,
	input  logic                 adv,
	input  logic                 mode,
	input  logic signed [DW-1:0] in_x,
	input  logic signed [DW-1:0] in_y,
	input  logic [ANG_W-1:0]     in_ang,
	output logic signed [DW-1:0] out_x,
	output logic signed [DW-1:0] out_y,
	output logic signed [ZW-1:0] out_z
);

	logic signed [DW-1:0] x_s [STAGES+1];
	logic signed [DW-1:0] y_s [STAGES+1];
	logic signed [ZW-1:0] z_s [STAGES+1];
	logic                 mode_s [STAGES+1];
	logic                 zero_s [STAGES+1];

	logic signed [DW-1:0] x0;
	logic signed [DW-1:0] y0;
	logic signed [ZW-1:0] z0;
	logic                 zero0;
	logic signed [ZW-1:0] a;

	// Vectoring turns a left-half vector by a half turn; rotation folds the
	// angle into a quarter turn either side of zero.
	always_comb begin
		x0 = in_x;
		y0 = in_y;
		z0 = '0;
		zero0 = 1'b0;
		a = ZW'($signed(in_ang));
		if (mode == ACT_FWD) begin
			zero0 = (in_x == '0) && (in_y == '0);
			if (in_x < 0) begin
				z0 = (in_y < 0) ? -HALF_TURN : HALF_TURN;
				x0 = -in_x;
				y0 = -in_y;
			end
		end else begin
			if (a > QUARTER_TURN) begin
				x0 = -in_x;
				z0 = a - HALF_TURN;
			end else if (a < -QUARTER_TURN) begin
				x0 = -in_x;
				z0 = a + HALF_TURN;
			end else begin
				z0 = a;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			x_s[0] <= x0;
			y_s[0] <= y0;
			z_s[0] <= z0;
			mode_s[0] <= mode;
			zero_s[0] <= zero0;
		end
	end

	for (genvar i = 0; i < STAGES; i++) begin : g_stage
		localparam logic signed [ZW-1:0] STEP = ZW'(atan_step(i));
		logic turn_neg;
		assign turn_neg = (mode_s[i] == ACT_FWD) ? y_s[i][DW-1] : !z_s[i][ZW-1];
		always_ff @(posedge clk) begin
			if (adv) begin
				if (turn_neg) begin
					x_s[i+1] <= x_s[i] - (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] + (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] - STEP;
				end else begin
					x_s[i+1] <= x_s[i] + (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] - (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] + STEP;
				end
				mode_s[i+1] <= mode_s[i];
				zero_s[i+1] <= zero_s[i];
			end
		end
	end

	// A vector at the origin reports zero length and zero angle.
	assign out_x = zero_s[STAGES] ? '0 : x_s[STAGES];
	assign out_y = y_s[STAGES];
	assign out_z = zero_s[STAGES] ? '0 : z_s[STAGES];

endmodule

FILE: rtl/core/spherical_frame_position_converter_core.sv
// Throughput: one transaction per cycle while the result is not stalled; the whole pipeline advances together.
// Most of the pipeline depth lies in the two chained CORDIC pipelines, one stage per iteration.
// A stalled result holds the pipeline; nothing is dropped or repeated.
// Reset clears all valid bits and loads the identity matrix and the default radius.
`include "spherical_frame_position_converter_core_defines.svh"
module spherical_frame_position_converter_core import sfpc_pkg::*; #(
	parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_ready,
	input  req_t              req_data,
	output logic              rsp_valid,
	input  logic              rsp_ready,
	output rsp_t              rsp_data,
	input  logic              cfg_we,
	input  logic [CFG_IW-1:0] cfg_index,
	input  logic [ROW_W-1:0]  cfg_data
);

	// Total pipeline depth: matrix (3), pre (1), gain (2), CORDIC (S+1),
	// gain (2), CORDIC (S+1), gain (2), post (1), matrix (3).
	localparam int LAT = 2 * CORDIC_STAGES + 16;
	localparam int CS = CORDIC_STAGES + 1;
	localparam logic signed [DW-1:0] SCALE_HALF = DW'(1) <<< (SU - 1);
	localparam coord_t ANG_LIM = coord_t'(64'sd1 <<< 32);

	typedef struct packed {
		logic                 action;
		logic                 flag;
		logic signed [DW-1:0] y;
		logic signed [DW-1:0] z;
		logic [ANG_W-1:0]     lat;
		logic [ANG_W-1:0]     lon;
	} sa_t;

	typedef struct packed {
		logic                 action;
		logic                 flag;
		logic signed [DW-1:0] z;
		logic [ANG_W-1:0]     lon;
	} sb_t;

	typedef struct packed {
		logic                 action;
		logic                 flag;
		logic signed [DW-1:0] z;
		logic [ANG_W-1:0]     lon;
		logic signed [ZW-1:0] ang1;
		logic signed [DW-1:0] hold;
	} sc_t;

	typedef struct packed {
		logic                 action;
		logic                 flag;
		logic signed [ZW-1:0] ang1;
		logic signed [DW-1:0] hold;
	} sd_t;

	typedef struct packed {
		logic                 action;
		logic                 flag;
		logic signed [ZW-1:0] lon;
		logic signed [ZW-1:0] lat;
		logic signed [DW-1:0] ys;
		logic signed [DW-1:0] zs;
	} se_t;

	typedef struct packed {
		logic action;
		logic flag;
	} sf_t;

	// Configuration registers.
	logic [ROW_W-1:0] row_q [3];
	logic [RAD_W-1:0] rad_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q[0] <= ROW_W'(ENTRY_ONE) << (0 * EB);
			row_q[1] <= ROW_W'(ENTRY_ONE) << (1 * EB);
			row_q[2] <= ROW_W'(ENTRY_ONE) << (2 * EB);
			rad_q <= RAD_W'(64'd6378137000);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_ROW_ZERO: row_q[0] <= cfg_data;
				REG_ROW_ONE: row_q[1] <= cfg_data;
				REG_ROW_TWO: row_q[2] <= cfg_data;
				REG_RADIUS: rad_q <= cfg_data[RAD_W-1:0];
				default: ;
			endcase
		end
	end

	// Global advance: every stage moves when the output register is free or
	// being drained. Valid bits travel in a shift register beside the data.
	logic           adv;
	logic [LAT-1:0] vld_q;

	assign adv = !vld_q[LAT-1] || rsp_ready;
	assign req_ready = adv;
	assign rsp_valid = vld_q[LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[LAT-2:0], req_valid};
		end
	end

	// Front matrix: the configured rotation for the forward action, identity
	// (an exact pass-through) for the inverse action.
	coord_t m1_v [3];
	entry_t m1_e [3][3];
	coord_t m1_res [3];
	logic   m1_clip;
	logic   act_m1_s [3];

	always_comb begin
		m1_v[0] = req_data.coord_first;
		m1_v[1] = req_data.coord_second;
		m1_v[2] = req_data.coord_third;
		for (int r = 0; r < 3; r++) begin
			for (int c = 0; c < 3; c++) begin
				if (req_data.action == ACT_INV) begin
					m1_e[r][c] = (r == c) ? ENTRY_ONE : '0;
				end else begin
					m1_e[r][c] = row_q[r][EB*c +: EB];
				end
			end
		end
	end

	sfpc_matrix u_mat_front (
		.clk  (clk),
		.adv  (adv),
		.v    (m1_v),
		.e    (m1_e),
		.res  (m1_res),
		.clip (m1_clip)
	);

	always_ff @(posedge clk) begin
		if (adv) begin
			act_m1_s[0] <= req_data.action;
			act_m1_s[1] <= act_m1_s[0];
			act_m1_s[2] <= act_m1_s[1];
		end
	end

	// Pre stage: scale positions up for CORDIC, or form the sphere radius
	// plus altitude for the inverse action.
	logic signed [CW+1:0] rsum;
	sat_t                 rsat;
	logic signed [DW-1:0] gin;
	sa_t                  pre_side;
	logic signed [DW-1:0] gin_s1;
	sa_t                  pre_s1;

	always_comb begin
		rsum = (CW+2)'(m1_res[2]) + (CW+2)'(rad_q);
		rsat = sat_cw(SW'(rsum));
		pre_side.action = act_m1_s[2];
		pre_side.y = DW'(m1_res[1]) <<< SU;
		pre_side.z = DW'(m1_res[2]) <<< SU;
		pre_side.lat = m1_res[0][ANG_W-1:0];
		pre_side.lon = m1_res[1][ANG_W-1:0];
		if (act_m1_s[2] == ACT_INV) begin
			gin = DW'(rsat.val) <<< SU;
			pre_side.flag = m1_clip | rsat.clip;
		end else begin
			gin = DW'(m1_res[0]) <<< SU;
			pre_side.flag = m1_clip;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			gin_s1 <= gin;
			pre_s1 <= pre_side;
		end
	end

	// First gain unit: applied to the radius only in the inverse action.
	logic signed [DW-1:0] ga;
	sa_t                  sa_s [2];

	sfpc_gain u_gain_a (
		.clk (clk),
		.adv (adv),
		.en  (pre_s1.action == ACT_INV),
		.v   (gin_s1),
		.q   (ga)
	);

	always_ff @(posedge clk) begin
		if (adv) begin
			sa_s[0] <= pre_s1;
			sa_s[1] <= sa_s[0];
		end
	end

	// First CORDIC: longitude and horizontal length, or rotation by latitude.
	logic signed [DW-1:0] c1_y_in;
	logic signed [DW-1:0] c1_x;
	logic signed [DW-1:0] c1_y;
	logic signed [ZW-1:0] c1_z;
	sb_t                  sb_in;
	sb_t                  sb_s [CS];

	assign c1_y_in = (sa_s[1].action == ACT_INV) ? '0 : sa_s[1].y;

	always_comb begin
		sb_in.action = sa_s[1].action;
		sb_in.flag = sa_s[1].flag;
		sb_in.z = sa_s[1].z;
		sb_in.lon = sa_s[1].lon;
	end

	sfpc_cordic #(.STAGES(CORDIC_STAGES)) u_cordic_a (
		.clk    (clk),
		.adv    (adv),
		.mode   (sa_s[1].action),
		.in_x   (ga),
		.in_y   (c1_y_in),
		.in_ang (sa_s[1].lat),
		.out_x  (c1_x),
		.out_y  (c1_y),
		.out_z  (c1_z)
	);

	always_ff @(posedge clk) begin
		if (adv) begin
			sb_s[0] <= sb_in;
			for (int k = 1; k < CS; k++) begin
				sb_s[k] <= sb_s[k-1];
			end
		end
	end

	// Second gain unit: always applied to the first CORDIC's x output.
	logic signed [DW-1:0] gb;
	sc_t                  sc_in;
	sc_t                  sc_s [2];

	always_comb begin
		sc_in.action = sb_s[CS-1].action;
		sc_in.flag = sb_s[CS-1].flag;
		sc_in.z = sb_s[CS-1].z;
		sc_in.lon = sb_s[CS-1].lon;
		sc_in.ang1 = c1_z;
		sc_in.hold = c1_y;
	end

	sfpc_gain u_gain_b (
		.clk (clk),
		.adv (adv),
		.en  (1'b1),
		.v   (c1_x),
		.q   (gb)
	);

	always_ff @(posedge clk) begin
		if (adv) begin
			sc_s[0] <= sc_in;
			sc_s[1] <= sc_s[0];
		end
	end

	// Second CORDIC: latitude and full length, or rotation by longitude.
	logic signed [DW-1:0] c2_y_in;
	logic signed [DW-1:0] c2_x;
	logic signed [DW-1:0] c2_y;
	logic signed [ZW-1:0] c2_z;
	sd_t                  sd_in;
	sd_t                  sd_s [CS];

	assign c2_y_in = (sc_s[1].action == ACT_INV) ? '0 : sc_s[1].z;

	always_comb begin
		sd_in.action = sc_s[1].action;
		sd_in.flag = sc_s[1].flag;
		sd_in.ang1 = sc_s[1].ang1;
		sd_in.hold = sc_s[1].hold;
	end

	sfpc_cordic #(.STAGES(CORDIC_STAGES)) u_cordic_b (
		.clk    (clk),
		.adv    (adv),
		.mode   (sc_s[1].action),
		.in_x   (gb),
		.in_y   (c2_y_in),
		.in_ang (sc_s[1].lon),
		.out_x  (c2_x),
		.out_y  (c2_y),
		.out_z  (c2_z)
	);

	always_ff @(posedge clk) begin
		if (adv) begin
			sd_s[0] <= sd_in;
			for (int k = 1; k < CS; k++) begin
				sd_s[k] <= sd_s[k-1];
			end
		end
	end

	// Third gain unit: applied to the length only in the forward action.
	logic signed [DW-1:0] gc;
	se_t                  se_in;
	se_t                  se_s [2];

	always_comb begin
		se_in.action = sd_s[CS-1].action;
		se_in.flag = sd_s[CS-1].flag;
		se_in.lon = sd_s[CS-1].ang1;
		se_in.lat = c2_z;
		se_in.ys = c2_y;
		se_in.zs = sd_s[CS-1].hold;
	end

	sfpc_gain u_gain_c (
		.clk (clk),
		.adv (adv),
		.en  (sd_s[CS-1].action == ACT_FWD),
		.v   (c2_x),
		.q   (gc)
	);

	always_ff @(posedge clk) begin
		if (adv) begin
			se_s[0] <= se_in;
			se_s[1] <= se_s[0];
		end
	end

	// Post stage: scale lengths back down with half-up rounding and clip. The forward
	// action passes the angles through and subtracts the radius to get the altitude.
	logic signed [DW-1:0] so [3];
	sat_t                 psat [3];
	coord_t               post_r [3];
	logic                 post_flag;
	coord_t               post_r_s2 [3];
	sf_t                  post_s2;

	always_comb begin
		so[0] = (gc + SCALE_HALF) >>> SU;
		so[1] = (se_s[1].ys + SCALE_HALF) >>> SU;
		so[2] = (se_s[1].zs + SCALE_HALF) >>> SU;
		if (se_s[1].action == ACT_FWD) begin
			psat[0] = sat_cw(SW'(se_s[1].lat));
			psat[1] = sat_cw(SW'(se_s[1].lon));
			psat[2] = sat_cw(SW'(so[0]) - SW'(rad_q));
		end else begin
			psat[0] = sat_cw(SW'(so[0]));
			psat[1] = sat_cw(SW'(so[1]));
			psat[2] = sat_cw(SW'(so[2]));
		end
		for (int i = 0; i < 3; i++) begin
			post_r[i] = psat[i].val;
		end
		post_flag = se_s[1].flag | psat[0].clip | psat[1].clip | psat[2].clip;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			post_r_s2 <= post_r;
			post_s2.action <= se_s[1].action;
			post_s2.flag <= post_flag;
		end
	end

	// Back matrix: the transposed rotation for the inverse action, identity
	// for the forward action. Its last stage is the output register.
	entry_t m2_e [3][3];
	coord_t m2_res [3];
	logic   m2_clip;
	sf_t    sf_s [3];

	always_comb begin
		for (int r = 0; r < 3; r++) begin
			for (int c = 0; c < 3; c++) begin
				if (post_s2.action == ACT_INV) begin
					m2_e[r][c] = row_q[c][EB*r +: EB];
				end else begin
					m2_e[r][c] = (r == c) ? ENTRY_ONE : '0;
				end
			end
		end
	end

	sfpc_matrix u_mat_back (
		.clk  (clk),
		.adv  (adv),
		.v    (post_r_s2),
		.e    (m2_e),
		.res  (m2_res),
		.clip (m2_clip)
	);

	always_ff @(posedge clk) begin
		if (adv) begin
			sf_s[0] <= post_s2;
			sf_s[1] <= sf_s[0];
			sf_s[2] <= sf_s[1];
		end
	end

	always_comb begin
		rsp_data.result_first = m2_res[0];
		rsp_data.result_second = m2_res[1];
		rsp_data.result_third = m2_res[2];
		rsp_data.saturated = sf_s[2].flag | m2_clip;
	end

	// A waiting result must block new requests.
	`SFPC_ASSERT_NOW(a_stall_blocks_req, clk, arst_n, rsp_valid && !rsp_ready, !req_ready)
	// While stalled, no transaction moves inside the pipeline.
	`SFPC_ASSERT_NEXT(a_stall_freezes_pipe, clk, arst_n, !adv, vld_q == $past(vld_q))
	// Forward latitude stays within one full turn (2^32 angle units) either side of zero.
	`SFPC_ASSERT_NOW(a_lat_range, clk, arst_n, rsp_valid && (sf_s[2].action == ACT_FWD), (rsp_data.result_first <= ANG_LIM) && (rsp_data.result_first >= -ANG_LIM))

endmodule
